// ===== src/r2p_pkg.sv =====
// Shared types, widths and constants for the rectangular-to-polar converter.
// Used by every module under src; depends on nothing.
package r2p_pkg;

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned MAG_W    = COORD_W;
  localparam int unsigned OUT_W    = 25;

  localparam int unsigned SUMSQ_W  = 2 * MAG_W + 1;
  localparam int unsigned SQ_W     = SUMSQ_W + 1;
  localparam int unsigned SQ_STEPS = 25;
  localparam int unsigned SQ_TOP   = 2 * (SQ_STEPS - 1);
  localparam int unsigned RND_W    = OUT_W + 1;

  localparam int unsigned PRE_SHIFT = 30;
  localparam int unsigned CD_W      = MAG_W + PRE_SHIFT + 3;
  localparam int unsigned CD_STEPS  = 28;
  localparam int unsigned Z_W       = 32;
  localparam int unsigned ZC_W      = Z_W - 1;

  localparam logic [OUT_W-1:0] RADIUS_MAX = 25'd33554431;
  localparam logic [OUT_W-1:0] DEG_90     = 25'd5898240;
  localparam logic [OUT_W-1:0] DEG_180    = 25'd11796480;
  localparam logic [OUT_W-1:0] DEG_360    = 25'd23592960;
  localparam logic [ZC_W-1:0]  Z_DEG_90   = 31'd1509949440;
  localparam logic [Z_W-1:0]   Z_HALF_LSB = 32'd128;

  localparam logic REG_CENTER_X = 1'b0;
  localparam logic REG_CENTER_Y = 1'b1;

  // atan(2^-i) in degrees, signed Q8.24
  localparam logic signed [Z_W-1:0] ATAN_TAB [CD_STEPS] = '{
    32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
    32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
    32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
    32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
    32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
    32'sd917,       32'sd458,       32'sd229,       32'sd115,
    32'sd57,        32'sd29,        32'sd14,        32'sd7
  };

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic zero_x;
    logic zero_y;
  } tag_t;

endpackage

// ===== src/r2p_offset.sv =====
// Front stages: subtract the center, then take magnitudes and quadrant flags.
// Depends on r2p_pkg.
module r2p_offset (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [r2p_pkg::COORD_W-1:0] px,
  input  logic signed [r2p_pkg::COORD_W-1:0] py,
  input  logic signed [r2p_pkg::COORD_W-1:0] cx,
  input  logic signed [r2p_pkg::COORD_W-1:0] cy,
  output logic                              out_vld,
  output logic [r2p_pkg::MAG_W-1:0]         ax,
  output logic [r2p_pkg::MAG_W-1:0]         ay,
  output r2p_pkg::tag_t                     tag
);

  logic signed [r2p_pkg::DIFF_W-1:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [r2p_pkg::DIFF_W-1:0] mx, my;
  logic [r2p_pkg::MAG_W-1:0]         ax_r, ay_r;
  r2p_pkg::tag_t                     tag_r, tag_nxt;
  logic                              v1_r, v2_r;

  assign dx_nxt = {px[r2p_pkg::COORD_W-1], px} - {cx[r2p_pkg::COORD_W-1], cx};
  assign dy_nxt = {py[r2p_pkg::COORD_W-1], py} - {cy[r2p_pkg::COORD_W-1], cy};

  assign mx = dx_r[r2p_pkg::DIFF_W-1] ? -dx_r : dx_r;
  assign my = dy_r[r2p_pkg::DIFF_W-1] ? -dy_r : dy_r;

  always_comb begin
    tag_nxt.neg_x  = dx_r[r2p_pkg::DIFF_W-1];
    tag_nxt.neg_y  = dy_r[r2p_pkg::DIFF_W-1];
    tag_nxt.zero_x = (dx_r == '0);
    tag_nxt.zero_y = (dy_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      ax_r  <= mx[r2p_pkg::MAG_W-1:0];
      ay_r  <= my[r2p_pkg::MAG_W-1:0];
      tag_r <= tag_nxt;
    end
  end

  assign out_vld = v2_r;
  assign ax      = ax_r;
  assign ay      = ay_r;
  assign tag     = tag_r;

endmodule

// ===== src/r2p_isqrt.sv =====
// Pipelined distance: squares, sum, one root digit per stage, round, clamp.
// Depends on r2p_pkg.
module r2p_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [r2p_pkg::MAG_W-1:0]   ax,
  input  logic [r2p_pkg::MAG_W-1:0]   ay,
  output logic                        out_vld,
  output logic [r2p_pkg::OUT_W-1:0]   radius
);

  localparam int unsigned PROD_W = 2 * r2p_pkg::MAG_W;

  logic [PROD_W-1:0]              pa_r, pb_r;
  logic [r2p_pkg::SQ_W-1:0]       sum_r;
  logic [r2p_pkg::SQ_W-1:0]       s_r [r2p_pkg::SQ_STEPS];
  logic [r2p_pkg::SQ_W-1:0]       q_r [r2p_pkg::SQ_STEPS];
  logic [r2p_pkg::RND_W-1:0]      rnd_r, rnd_nxt;
  logic [r2p_pkg::OUT_W-1:0]      radius_r, radius_nxt;
  logic                           vp_r, vs_r, vrnd_r, vout_r;
  logic [r2p_pkg::SQ_STEPS-1:0]   vstep_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= ax * ax;
      pb_r  <= ay * ay;
      sum_r <= r2p_pkg::SQ_W'(pa_r) + r2p_pkg::SQ_W'(pb_r);
    end
  end

  for (genvar k = 0; k < r2p_pkg::SQ_STEPS; k++) begin : g_step
    localparam logic [r2p_pkg::SQ_W-1:0] BIT =
      r2p_pkg::SQ_W'(1) << (r2p_pkg::SQ_TOP - 2 * k);
    logic [r2p_pkg::SQ_W-1:0] sp, qp, trial, s_nxt, q_nxt;

    if (k == 0) begin : g_first
      assign sp = sum_r;
      assign qp = '0;
    end else begin : g_rest
      assign sp = s_r[k-1];
      assign qp = q_r[k-1];
    end

    always_comb begin
      trial = qp + BIT;
      if (sp >= trial) begin
        s_nxt = sp - trial;
        q_nxt = (qp >> 1) + BIT;
      end else begin
        s_nxt = sp;
        q_nxt = qp >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k] <= s_nxt;
        q_r[k] <= q_nxt;
      end
    end
  end

  always_comb begin
    rnd_nxt = q_r[r2p_pkg::SQ_STEPS-1][r2p_pkg::RND_W-1:0];
    if (s_r[r2p_pkg::SQ_STEPS-1] > q_r[r2p_pkg::SQ_STEPS-1]) begin
      rnd_nxt = rnd_nxt + r2p_pkg::RND_W'(1);
    end
    if (rnd_r > r2p_pkg::RND_W'(r2p_pkg::RADIUS_MAX)) begin
      radius_nxt = r2p_pkg::RADIUS_MAX;
    end else begin
      radius_nxt = rnd_r[r2p_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_r    <= rnd_nxt;
      radius_r <= radius_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r    <= 1'b0;
      vs_r    <= 1'b0;
      vstep_r <= '0;
      vrnd_r  <= 1'b0;
      vout_r  <= 1'b0;
    end else if (en) begin
      vp_r    <= in_vld;
      vs_r    <= vp_r;
      vstep_r <= {vstep_r[r2p_pkg::SQ_STEPS-2:0], vs_r};
      vrnd_r  <= vstep_r[r2p_pkg::SQ_STEPS-1];
      vout_r  <= vrnd_r;
    end
  end

  assign out_vld = vout_r;
  assign radius  = radius_r;

endmodule

// ===== src/r2p_cordic.sv =====
// Pipelined CORDIC vectoring for the first-quadrant angle, one rotation per
// stage, then clamp and round to Q9.16 degrees. Depends on r2p_pkg.
module r2p_cordic (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [r2p_pkg::MAG_W-1:0]   ax,
  input  logic [r2p_pkg::MAG_W-1:0]   ay,
  input  r2p_pkg::tag_t               tag_in,
  output logic                        out_vld,
  output logic [r2p_pkg::OUT_W-1:0]   angle,
  output r2p_pkg::tag_t               tag_out
);

  logic signed [r2p_pkg::CD_W-1:0] x_r [r2p_pkg::CD_STEPS];
  logic signed [r2p_pkg::CD_W-1:0] y_r [r2p_pkg::CD_STEPS];
  logic signed [r2p_pkg::Z_W-1:0]  z_r [r2p_pkg::CD_STEPS];
  r2p_pkg::tag_t                   tag_r [r2p_pkg::CD_STEPS];
  logic [r2p_pkg::CD_STEPS-1:0]    vld_r;

  logic signed [r2p_pkg::Z_W-1:0]  z_last;
  logic [r2p_pkg::ZC_W-1:0]        zc;
  logic [r2p_pkg::Z_W-1:0]         zr;
  logic [r2p_pkg::OUT_W-1:0]       angle_r, angle_nxt;
  r2p_pkg::tag_t                   tago_r;
  logic                            vout_r;

  for (genvar i = 0; i < r2p_pkg::CD_STEPS; i++) begin : g_rot
    logic signed [r2p_pkg::CD_W-1:0] xp, yp, xs, ys, x_nxt, y_nxt;
    logic signed [r2p_pkg::Z_W-1:0]  zp, z_nxt;
    r2p_pkg::tag_t                   tp;

    if (i == 0) begin : g_first
      assign xp = r2p_pkg::CD_W'({ax, {r2p_pkg::PRE_SHIFT{1'b0}}});
      assign yp = r2p_pkg::CD_W'({ay, {r2p_pkg::PRE_SHIFT{1'b0}}});
      assign zp = '0;
      assign tp = tag_in;
    end else begin : g_rest
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
      assign tp = tag_r[i-1];
    end

    always_comb begin
      xs = xp >>> i;
      ys = yp >>> i;
      if (!yp[r2p_pkg::CD_W-1]) begin
        x_nxt = xp + ys;
        y_nxt = yp - xs;
        z_nxt = zp + r2p_pkg::ATAN_TAB[i];
      end else begin
        x_nxt = xp - ys;
        y_nxt = yp + xs;
        z_nxt = zp - r2p_pkg::ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]   <= x_nxt;
        y_r[i]   <= y_nxt;
        z_r[i]   <= z_nxt;
        tag_r[i] <= tp;
      end
    end
  end

  assign z_last = z_r[r2p_pkg::CD_STEPS-1];

  always_comb begin
    if (z_last[r2p_pkg::Z_W-1]) begin
      zc = '0;
    end else if (z_last[r2p_pkg::ZC_W-1:0] > r2p_pkg::Z_DEG_90) begin
      zc = r2p_pkg::Z_DEG_90;
    end else begin
      zc = z_last[r2p_pkg::ZC_W-1:0];
    end
    zr        = r2p_pkg::Z_W'(zc) + r2p_pkg::Z_HALF_LSB;
    angle_nxt = r2p_pkg::OUT_W'(zr[r2p_pkg::Z_W-1:8]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
      tago_r  <= tag_r[r2p_pkg::CD_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      vout_r <= 1'b0;
    end else if (en) begin
      vld_r  <= {vld_r[r2p_pkg::CD_STEPS-2:0], in_vld};
      vout_r <= vld_r[r2p_pkg::CD_STEPS-1];
    end
  end

  assign out_vld = vout_r;
  assign angle   = angle_r;
  assign tag_out = tago_r;

endmodule

// ===== src/rect_to_polar_about_center.sv =====
// Rectangular to polar about a programmable center; one point per cycle.
// Pipeline of 2 offset stages, 29 CORDIC / root-digit stages and 1 output stage;
// throughput one transfer per cycle.
// A stall on out_tready freezes the whole pipeline; in_tready follows it.
// Reset (rst_n, synchronous) empties the pipeline and clears both center registers.
// Depends on r2p_pkg, r2p_offset, r2p_isqrt, r2p_cordic.
module rect_to_polar_about_center (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // point_x [23:0], point_y [47:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // radius [24:0], bearing [49:25], zero [55:50]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic signed [r2p_pkg::COORD_W-1:0] cx_r, cy_r;
  logic                               adv, cfg_wr;

  logic                               off_vld;
  logic [r2p_pkg::MAG_W-1:0]          ax, ay;
  r2p_pkg::tag_t                      off_tag, cd_tag;

  logic                               sq_vld, cd_vld;
  logic [r2p_pkg::OUT_W-1:0]          radius, angle;

  logic [r2p_pkg::OUT_W-1:0]          t;
  logic [r2p_pkg::RND_W-1:0]          b_raw;
  logic [r2p_pkg::OUT_W-1:0]          bearing_nxt;

  logic                               out_vld_r;
  logic [r2p_pkg::OUT_W-1:0]          radius_r, bearing_r;

  assign adv        = !out_vld_r || out_tready;
  assign in_tready  = adv;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        r2p_pkg::REG_CENTER_X: cx_r <= cfg_pwdata[r2p_pkg::COORD_W-1:0];
        r2p_pkg::REG_CENTER_Y: cy_r <= cfg_pwdata[r2p_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      r2p_pkg::REG_CENTER_X: cfg_prdata = 32'(cx_r);
      r2p_pkg::REG_CENTER_Y: cfg_prdata = 32'(cy_r);
      default:               cfg_prdata = '0;
    endcase
  end

  r2p_offset u_offset (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (in_tvalid),
    .px      (in_tdata[23:0]),
    .py      (in_tdata[47:24]),
    .cx      (cx_r),
    .cy      (cy_r),
    .out_vld (off_vld),
    .ax      (ax),
    .ay      (ay),
    .tag     (off_tag)
  );

  r2p_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (off_vld),
    .ax      (ax),
    .ay      (ay),
    .out_vld (sq_vld),
    .radius  (radius)
  );

  r2p_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (off_vld),
    .ax      (ax),
    .ay      (ay),
    .tag_in  (off_tag),
    .out_vld (cd_vld),
    .angle   (angle),
    .tag_out (cd_tag)
  );

  // place the first-quadrant angle into its quadrant
  always_comb begin
    if (cd_tag.zero_y) begin
      t = '0;
    end else if (cd_tag.zero_x) begin
      t = r2p_pkg::DEG_90;
    end else begin
      t = angle;
    end

    if (!cd_tag.neg_x && !cd_tag.neg_y) begin
      b_raw = r2p_pkg::RND_W'(t);
    end else if (cd_tag.neg_x && !cd_tag.neg_y) begin
      b_raw = r2p_pkg::RND_W'(r2p_pkg::DEG_180) - r2p_pkg::RND_W'(t);
    end else if (cd_tag.neg_x) begin
      b_raw = r2p_pkg::RND_W'(r2p_pkg::DEG_180) + r2p_pkg::RND_W'(t);
    end else begin
      b_raw = r2p_pkg::RND_W'(r2p_pkg::DEG_360) - r2p_pkg::RND_W'(t);
    end

    if (b_raw >= r2p_pkg::RND_W'(r2p_pkg::DEG_360)) begin
      bearing_nxt = r2p_pkg::OUT_W'(b_raw - r2p_pkg::RND_W'(r2p_pkg::DEG_360));
    end else begin
      bearing_nxt = b_raw[r2p_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= cd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      radius_r  <= radius;
      bearing_r <= bearing_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, bearing_r, radius_r};

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld == cd_vld)
    else $error("root and angle pipelines out of step");

  a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> bearing_r < r2p_pkg::DEG_360)
    else $error("bearing not below 360 degrees");

  a_center_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && radius_r == '0) |-> bearing_r == '0)
    else $error("point at center gave nonzero bearing");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |=> ($stable(radius_r) && $stable(bearing_r)
      && out_vld_r))
    else $error("result changed during stall");

endmodule
